// ===== hw/rtl/rotated_sprite_alpha_overlay_defines.svh =====
// Assertion macros for the sprite overlay checker.
`ifndef ROTATED_SPRITE_ALPHA_OVERLAY_DEFINES_SVH
`define ROTATED_SPRITE_ALPHA_OVERLAY_DEFINES_SVH

// Same-cycle implication, disabled while rst_sig is high.
`define RSO_ASSERT_IMP(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("overlay check failed");

// Next-cycle implication, disabled while rst_sig is high.
`define RSO_ASSERT_NXT(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("overlay check failed");

`endif

// ===== hw/rtl/rso_pkg.sv =====
// Types and constants shared by the sprite overlay modules.
`timescale 1ns / 1ps
`default_nettype none
package rso_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;
  localparam int ADDR_W     = 19;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE_COS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_SIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = 3'd5;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    logic signed [21:0] scale_cos;
    logic signed [21:0] scale_sin;
    logic signed [24:0] offset_x;
    logic signed [24:0] offset_y;
    logic [8:0]         tex_width;
    logic [8:0]         tex_height;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    scale_cos:  22'sd256,
    scale_sin:  22'sd0,
    offset_x:   25'sd0,
    offset_y:   25'sd0,
    tex_width:  9'd0,
    tex_height: 9'd0
  };

  // Word moving down the coordinate pipe. value is the texel for a load
  // and the background color for a pixel.
  typedef struct packed {
    logic        is_pixel;
    logic [15:0] index;
    logic [31:0] value;
  } item_t;

  // Coordinate pipe to texture memory.
  typedef struct packed {
    logic              is_pixel;
    logic              covered;
    logic [ADDR_W-1:0] addr;
    logic [15:0]       index;
    logic [31:0]       value;
  } mem_req_t;

  // Texture memory to blender.
  typedef struct packed {
    logic        covered;
    logic        tex_ok;
    logic [31:0] texel;
    logic [31:0] color;
  } tex_rd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rso_coord.sv =====
// Screen to texture coordinate pipeline: offset, rotate/scale, bounds, address.
`timescale 1ns / 1ps
`default_nettype none
module rso_coord #(
  parameter int COORD_FRAC_BITS = 8,
  parameter int SCALE_FRAC_BITS = 12
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire rso_pkg::cfg_t    cfg,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             req_type,
  input  wire logic [15:0]      texel_index,
  input  wire logic [31:0]      texel_value,
  input  wire logic [11:0]      pixel_x,
  input  wire logic [11:0]      pixel_y,
  input  wire logic [31:0]      pixel_color,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output rso_pkg::mem_req_t     out_req
);
  import rso_pkg::*;

  localparam int XW = 12 + COORD_FRAC_BITS;
  localparam int PW = ((XW + 1 > 25) ? XW + 1 : 25) + 1;
  localparam int MW = PW + 22;
  localparam int SW = MW + 1;
  localparam int SH = SCALE_FRAC_BITS + COORD_FRAC_BITS;
  localparam int TW = SW - SH;

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3, rdy4;
  item_t item1, item2, item3;

  logic signed [PW-1:0] px, py;
  logic signed [MW-1:0] p_xc, p_ys, p_yc, p_xs;
  logic signed [TW-1:0] tx, ty;

  logic [XW-1:0] xs, ys;
  logic signed [PW-1:0] px_next, py_next;
  logic signed [SW-1:0] tx_sum, ty_sum;
  logic inside_x, inside_y;
  logic [17:0] row_base;

  assign rdy4     = !out_valid || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    xs      = {pixel_x, {COORD_FRAC_BITS{1'b0}}};
    ys      = {pixel_y, {COORD_FRAC_BITS{1'b0}}};
    px_next = PW'($signed(cfg.offset_x)) + $signed(PW'(xs));
    py_next = PW'($signed(cfg.offset_y)) + $signed(PW'(ys));
    tx_sum  = SW'(p_xc) + SW'(p_ys);
    ty_sum  = SW'(p_yc) - SW'(p_xs);
    // floor shift: keep the upper bits of the exact sum
    inside_x = !tx[TW-1] && (tx[TW-2:9] == '0) && (tx[8:0] < cfg.tex_width);
    inside_y = !ty[TW-1] && (ty[TW-2:9] == '0) && (ty[8:0] < cfg.tex_height);
    row_base = ty[8:0] * cfg.tex_width;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      item1.is_pixel <= req_type;
      item1.index    <= texel_index;
      item1.value    <= req_type ? pixel_color : texel_value;
      px             <= px_next;
      py             <= py_next;
    end
    if (rdy2) begin
      item2 <= item1;
      p_xc  <= MW'(px) * MW'($signed(cfg.scale_cos));
      p_ys  <= MW'(py) * MW'($signed(cfg.scale_sin));
      p_yc  <= MW'(py) * MW'($signed(cfg.scale_cos));
      p_xs  <= MW'(px) * MW'($signed(cfg.scale_sin));
    end
    if (rdy3) begin
      item3 <= item2;
      tx    <= tx_sum[SW-1:SH];
      ty    <= ty_sum[SW-1:SH];
    end
    if (rdy4) begin
      out_req.is_pixel <= item3.is_pixel;
      out_req.covered  <= inside_x && inside_y;
      out_req.addr     <= ADDR_W'(row_base) + ADDR_W'(tx[8:0]);
      out_req.index    <= item3.index;
      out_req.value    <= item3.value;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/rso_texmem.sv =====
// Texture RAM: one write or one registered read per word, in pipeline order.
`timescale 1ns / 1ps
`default_nettype none
module rso_texmem #(
  parameter int TEX_DEPTH = 65536
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire rso_pkg::mem_req_t in_req,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output rso_pkg::tex_rd_t       out_rd
);
  import rso_pkg::*;

  localparam int AW = $clog2(TEX_DEPTH);

  logic [31:0] mem [TEX_DEPTH];
  logic [31:0] rdata;
  logic        covered_q, tex_ok_q;
  logic [31:0] color_q;
  logic        acc, wr_en, rd_en, rd_ok;

  assign in_ready = !out_valid || out_ready;
  assign acc      = in_valid && in_ready;
  assign wr_en    = acc && !in_req.is_pixel && (32'(in_req.index) < 32'(TEX_DEPTH));
  assign rd_en    = acc && in_req.is_pixel;
  assign rd_ok    = 32'(in_req.addr) < 32'(TEX_DEPTH);

  always_ff @(posedge clk) begin
    if (wr_en) mem[AW'(in_req.index)] <= in_req.value;
    if (rd_en) rdata <= mem[AW'(in_req.addr)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid && in_req.is_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      covered_q <= in_req.covered;
      tex_ok_q  <= rd_ok;
      color_q   <= in_req.value;
    end
  end

  always_comb begin
    out_rd.covered = covered_q;
    out_rd.tex_ok  = tex_ok_q;
    out_rd.texel   = rdata;
    out_rd.color   = color_q;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/rso_blend.sv =====
// Per-channel alpha blend and final word select, two stages.
`timescale 1ns / 1ps
`default_nettype none
module rso_blend (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire rso_pkg::tex_rd_t in_rd,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [31:0]           out_color,
  output logic                  covered
);
  import rso_pkg::*;

  logic        v1, rdy1, rdy2;
  logic        covered1, opaque1;
  logic [31:0] bg1;
  logic [23:0] rgb1;
  logic [15:0] pt1 [3];
  logic [15:0] pb1 [3];

  logic [31:0] tex;
  logic [7:0]  alpha, inv_alpha;
  logic [15:0] pt_next [3];
  logic [15:0] pb_next [3];
  logic [15:0] mix [3];
  logic [31:0] mixed, result;

  assign rdy2     = !out_valid || out_ready;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    // a read past the end of the store acts as a fully clear texel
    tex       = in_rd.tex_ok ? in_rd.texel : 32'h0;
    alpha     = tex[31:24];
    inv_alpha = ALPHA_OPAQUE - alpha;
    for (int i = 0; i < 3; i++) begin
      pt_next[i] = tex[8*i +: 8] * alpha;
      pb_next[i] = in_rd.color[8*i +: 8] * inv_alpha;
    end
    for (int i = 0; i < 3; i++) begin
      mix[i] = pt1[i] + pb1[i];
    end
    mixed = {8'h00, mix[2][15:8], mix[1][15:8], mix[0][15:8]};
    if (!covered1) begin
      result = bg1;
    end else if (opaque1) begin
      result = {8'h00, rgb1};
    end else begin
      result = mixed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      covered1 <= in_rd.covered;
      opaque1  <= (alpha == ALPHA_OPAQUE);
      bg1      <= in_rd.color;
      rgb1     <= tex[23:0];
      pt1      <= pt_next;
      pb1      <= pb_next;
    end
    if (rdy2) begin
      out_color <= result;
      covered   <= covered1;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/rotated_sprite_alpha_overlay.sv =====
// Top level of the rotated sprite overlay: config registers and pipeline.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------
//   cfg     | in        | cfg_we             | cfg_index, cfg_wdata
//   in      | in        | in_valid/in_ready  | req_type, texel_index, texel_value,
//           |           |                    | pixel_x, pixel_y, pixel_color
//   out     | out       | out_valid/out_ready| out_color, covered
//
// One word is accepted per cycle, loads and pixels alike, unless a stalled
// output backs up the pipe; the rate is set by the single texture RAM, which
// takes one write or one read per cycle. A pixel word passes 4 coordinate
// registers, the RAM read register and 2 blend registers on its way to the
// output, the first loaded at the accepting edge. A load word gives no result.
// rst clears the valid bits and config registers; the texture RAM is not
// cleared and needs no sweep. Each stage holds while the next is full, so
// bubbles collapse and a stalled output does not stop intake until full.
`timescale 1ns / 1ps
`default_nettype none
module rotated_sprite_alpha_overlay #(
  parameter int TEX_DEPTH       = 65536,
  parameter int COORD_FRAC_BITS = 8,
  parameter int SCALE_FRAC_BITS = 12
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration
  input  wire logic                            cfg_we,
  input  wire logic [rso_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rso_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // input words
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            req_type,
  input  wire logic [15:0]                     texel_index,
  input  wire logic [31:0]                     texel_value,
  input  wire logic [11:0]                     pixel_x,
  input  wire logic [11:0]                     pixel_y,
  input  wire logic [31:0]                     pixel_color,
  // result words
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [31:0]                          out_color,
  output logic                                 covered
);
  import rso_pkg::*;

  cfg_t     cfg;
  logic     co_valid, co_ready;
  mem_req_t co_req;
  logic     tm_valid, tm_ready;
  tex_rd_t  tm_rd;

  // Register file. The user must write only while the pipe is empty (the block
  // does not enforce it), so stages read these directly without shadow copies.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCALE_COS:  cfg.scale_cos  <= cfg_wdata[21:0];
        REG_SCALE_SIN:  cfg.scale_sin  <= cfg_wdata[21:0];
        REG_OFFSET_X:   cfg.offset_x   <= cfg_wdata[24:0];
        REG_OFFSET_Y:   cfg.offset_y   <= cfg_wdata[24:0];
        REG_TEX_WIDTH:  cfg.tex_width  <= cfg_wdata[8:0];
        REG_TEX_HEIGHT: cfg.tex_height <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  // position = offset + screen << frac, then rotate/scale and bound check;
  // the texel address is x + y * width for covered pixels
  rso_coord #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .SCALE_FRAC_BITS(SCALE_FRAC_BITS)
  ) u_coord (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .texel_index (texel_index),
    .texel_value (texel_value),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .out_valid   (co_valid),
    .out_ready   (co_ready),
    .out_req     (co_req)
  );

  // Loads and reads hit the RAM at the same stage in arrival order, so a
  // pixel always sees every load ahead of it and none behind it.
  rso_texmem #(
    .TEX_DEPTH(TEX_DEPTH)
  ) u_texmem (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (co_valid),
    .in_ready  (co_ready),
    .in_req    (co_req),
    .out_valid (tm_valid),
    .out_ready (tm_ready),
    .out_rd    (tm_rd)
  );

  // alpha blend; last stage is the output register
  rso_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tm_valid),
    .in_ready  (tm_ready),
    .in_rd     (tm_rd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_color (out_color),
    .covered   (covered)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/rso_checker.sv =====
// Port-level checks for the sprite overlay, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "rotated_sprite_alpha_overlay_defines.svh"
module rso_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_color,
  input wire logic        covered
);

  logic out_stall;

  assign out_stall = out_valid && !out_ready;

  // a stalled result word holds
  `RSO_ASSERT_NXT(a_out_hold, clk, rst, out_stall, out_valid && $stable({out_color, covered}))

  // covered results always have the top byte cleared
  `RSO_ASSERT_IMP(a_covered_top, clk, rst, out_valid && covered, out_color[31:24] == 8'h00)

  // reset empties the pipe
  `RSO_ASSERT_NXT(a_reset_empty, clk, 1'b0, rst, !out_valid)

  // with the sink ready nothing can back up to the input
  `RSO_ASSERT_IMP(a_ready_flow, clk, rst, out_ready, in_ready)

endmodule

bind rotated_sprite_alpha_overlay rso_checker u_rso_checker (.*);
`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the rotated sprite overlay: predictor, driver, monitor.
`timescale 1ns / 1ps
module tb_top;
  import rso_pkg::*;

  localparam int     TEX_DEPTH    = 65536;
  localparam int     FRAC_SHIFT   = 20;      // scale fraction plus coordinate fraction
  localparam int     COORD_SHIFT  = 8;
  localparam int     RESET_CYCLES = 7;
  localparam int     DRAIN_CYCLES = 16;      // loads give no result
  localparam int     PHASES       = 10;
  localparam int     PHASE_WORDS  = 100;     // covered pixels add loads on top of these
  localparam longint CYCLE_LIMIT  = 500000;

  localparam logic REQ_TEXEL = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  // indexes past the last register; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef struct {
    logic        req;
    logic [15:0] index;
    logic [31:0] texel;
    logic [11:0] x;
    logic [11:0] y;
    logic [31:0] color;
  } overlay_word_t;

  typedef struct {
    logic [31:0] color;
    logic        covered;
  } pixel_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  req_type = REQ_TEXEL;
  logic [15:0]           texel_index = '0;
  logic [31:0]           texel_value = '0;
  logic [11:0]           pixel_x = '0;
  logic [11:0]           pixel_y = '0;
  logic [31:0]           pixel_color = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [31:0]           out_color;
  logic                  covered;

  rotated_sprite_alpha_overlay i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .texel_index (texel_index),
    .texel_value (texel_value),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_color   (out_color),
    .covered     (covered)
  );

  always #2 clk = ~clk;

  // Predictor state: live register copy and texture contents as the block sees them.
  cfg_t          geom = CFG_RESET;
  logic [31:0]   texture_mem [0:TEX_DEPTH-1];
  // Stimulus side bookkeeping: which texels a queued load will have written.
  bit            texel_loaded [0:TEX_DEPTH-1];

  overlay_word_t words_to_send[$];
  pixel_result_t expected_pixels[$];
  int            words_in_flight = 0;
  int            mismatches = 0;
  longint        cycle_count = 0;

  // Traffic shaping: 0 means no idling, else a burst starts with a chance of one in that many.
  int            gap_odds = 0;
  int            stall_odds = 0;
  int            gap_left = 0;
  int            stall_left = 0;

  // Screen window the random pixels are drawn from in the current phase.
  int            win_x = 2048;
  int            win_y = 2048;
  int            win_r = 2047;

  // Driver-side scratch for prediction.
  overlay_word_t next_word;
  pixel_result_t predicted;
  pixel_result_t seen;
  longint        hit_addr;
  logic [31:0]   texel;
  int            alpha;
  int            mix;

  // Screen pixel to texture: exact products, floor shifts. Returns 1 when inside.
  function automatic logic locate_texel(input logic [11:0] x, input logic [11:0] y,
                                        output longint addr);
    longint px, py, c, s, tx, ty, w, h;
    c  = longint'($signed(geom.scale_cos));
    s  = longint'($signed(geom.scale_sin));
    px = longint'($signed(geom.offset_x));
    py = longint'($signed(geom.offset_y));
    px = px + (longint'(x) << COORD_SHIFT);
    py = py + (longint'(y) << COORD_SHIFT);
    tx = (px * c + py * s) >>> FRAC_SHIFT;
    ty = (py * c - px * s) >>> FRAC_SHIFT;
    w  = longint'(geom.tex_width);
    h  = longint'(geom.tex_height);
    addr = tx + ty * w;
    return (tx >= 0) && (ty >= 0) && (tx < w) && (ty < h);
  endfunction

  // Alpha is biased toward the opaque and fully clear cases.
  function automatic logic [31:0] random_texel();
    logic [7:0] a;
    case ($urandom_range(0, 4))
      0: a = ALPHA_OPAQUE;
      1: a = 8'h00;
      default: a = 8'($urandom);
    endcase
    return {a, 24'($urandom)};
  endfunction

  task automatic push_load(input logic [15:0] idx, input logic [31:0] value);
    overlay_word_t word;
    word.req   = REQ_TEXEL;
    word.index = idx;
    word.texel = value;
    word.x     = 12'($urandom);
    word.y     = 12'($urandom);
    word.color = $urandom;
    texel_loaded[idx] = 1'b1;
    words_to_send.push_back(word);
    words_in_flight++;
  endtask

  // A pixel that lands on a texel nobody wrote yet gets a load queued ahead of it.
  task automatic push_pixel(input logic [11:0] x, input logic [11:0] y,
                            input logic [31:0] color);
    overlay_word_t word;
    longint        addr;
    if (locate_texel(x, y, addr) && addr < TEX_DEPTH && !texel_loaded[addr]) begin
      push_load(addr[15:0], random_texel());
    end
    word.req   = REQ_PIXEL;
    word.index = 16'($urandom);
    word.texel = $urandom;
    word.x     = x;
    word.y     = y;
    word.color = color;
    words_to_send.push_back(word);
    words_in_flight++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_SCALE_COS:  geom.scale_cos  = data[21:0];
      REG_SCALE_SIN:  geom.scale_sin  = data[21:0];
      REG_OFFSET_X:   geom.offset_x   = data[24:0];
      REG_OFFSET_Y:   geom.offset_y   = data[24:0];
      REG_TEX_WIDTH:  geom.tex_width  = data[8:0];
      REG_TEX_HEIGHT: geom.tex_height = data[8:0];
      default: ;
    endcase
  endtask

  // Unused upper data bits carry noise; the block must drop them.
  task automatic set_geometry(input longint sc, input longint ss, input longint ox,
                              input longint oy, input int w, input int h);
    write_reg(REG_SCALE_COS,  {3'($urandom), sc[21:0]});
    write_reg(REG_SCALE_SIN,  {3'($urandom), ss[21:0]});
    write_reg(REG_OFFSET_X,   ox[24:0]);
    write_reg(REG_OFFSET_Y,   oy[24:0]);
    write_reg(REG_TEX_WIDTH,  {16'($urandom), w[8:0]});
    write_reg(REG_TEX_HEIGHT, {16'($urandom), h[8:0]});
    write_reg(REG_SPARE_6,    25'($urandom));
    write_reg(REG_SPARE_7,    25'($urandom));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Registers may only change with the pipe empty, so wait out every word.
  task automatic drain_pipe();
    while (words_in_flight != 0 || expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Picks a sprite placement for one phase. Rotated phases aim the texture
  // center at a random screen point so that most window pixels land inside.
  task automatic plan_phase(input int p);
    real    ang, mag, c, s, k, ux, uy, reach;
    longint sc, ss, ox, oy;
    int     w, h, sx, sy;
    if (p == 3) begin
      w = 256;
      h = 256;
    end else if (p == 7) begin
      w = 511;
      h = $urandom_range(200, 511);
    end else begin
      w = $urandom_range(1, 40);
      h = $urandom_range(1, 40);
    end
    sx = $urandom_range(0, 4095);
    sy = $urandom_range(0, 4095);
    if (p == 2) begin
      // register extremes, pixels anywhere on screen
      sc = $urandom_range(0, 1) ? -2097152 : 2097151;
      ss = $urandom_range(0, 1) ? -2097152 : 2097151;
      ox = $urandom_range(0, 1) ? -16777216 : 16777215;
      oy = $urandom_range(0, 1) ? -16777216 : 16777215;
      w  = 511;
      h  = 511;
      sx = 2048;
      sy = 2048;
      win_r = 2047;
    end else if (p == 5) begin
      // zero scale: every pixel folds onto texel zero
      sc = 0;
      ss = 0;
      ox = longint'($urandom_range(0, 33554431)) - 16777216;
      oy = longint'($urandom_range(0, 33554431)) - 16777216;
      sx = 2048;
      sy = 2048;
      win_r = 2047;
    end else begin
      ang = $urandom_range(0, 359) * 3.14159265 / 180.0;
      mag = $urandom_range(128, 32768);
      sc  = $rtoi(mag * $cos(ang));
      ss  = $rtoi(mag * $sin(ang));
      c   = sc;
      s   = ss;
      // invert the rotation to find where the texture center sits on screen
      k   = 4096.0 / (c * c + s * s);
      ux  = k * (c * w / 2.0 - s * h / 2.0);
      uy  = k * (s * w / 2.0 + c * h / 2.0);
      ox  = $rtoi(256.0 * (ux - sx));
      oy  = $rtoi(256.0 * (uy - sy));
      ox  = (ox > 16777215) ? 16777215 : (ox < -16777216) ? -16777216 : ox;
      oy  = (oy > 16777215) ? 16777215 : (oy < -16777216) ? -16777216 : oy;
      reach = (w + h) * 4096.0 / $sqrt(c * c + s * s);
      win_r = (reach > 2047.0) ? 2047 : (reach < 2.0) ? 2 : $rtoi(reach);
    end
    win_x = sx;
    win_y = sy;
    set_geometry(sc, ss, ox, oy, w, h);
  endtask

  // Mostly pixels aimed at the sprite, some anywhere, some texel rewrites.
  task automatic run_random_phase(input int count);
    int     made, roll, tries, x, y, area;
    longint addr;
    area = int'(geom.tex_width) * int'(geom.tex_height);
    if (area > TEX_DEPTH) area = TEX_DEPTH;
    for (made = 0; made < count; made++) begin
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
        if (area > 0 && $urandom_range(0, 1) == 1) begin
          push_load(16'($urandom_range(0, area - 1)), random_texel());
        end else begin
          push_load(16'($urandom), random_texel());
        end
      end else if (roll < 25) begin
        push_pixel(12'($urandom), 12'($urandom), $urandom);
      end else begin
        x = win_x;
        y = win_y;
        for (tries = 0; tries < 8; tries++) begin
          x = win_x + int'($urandom_range(0, 2 * win_r)) - win_r;
          y = win_y + int'($urandom_range(0, 2 * win_r)) - win_r;
          x = (x < 0) ? 0 : (x > 4095) ? 4095 : x;
          y = (y < 0) ? 0 : (y > 4095) ? 4095 : y;
          if (locate_texel(12'(x), 12'(y), addr)) break;
        end
        push_pixel(12'(x), 12'(y), $urandom);
      end
    end
  endtask

  // Driver: predicts each accepted word, then presents the next one unless
  // an idle burst is running. Valid only drops after an acceptance.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        words_in_flight--;
        if (req_type == REQ_TEXEL) begin
          texture_mem[texel_index] = texel_value;
        end else begin
          predicted.color   = pixel_color;
          predicted.covered = locate_texel(pixel_x, pixel_y, hit_addr);
          if (predicted.covered) begin
            // past the end of the store the texel reads as clear black
            texel = (hit_addr < TEX_DEPTH) ? texture_mem[hit_addr] : 32'h0;
            alpha = int'(texel[31:24]);
            predicted.color[31:24] = 8'h00;
            if (texel[31:24] == ALPHA_OPAQUE) begin
              predicted.color[23:0] = texel[23:0];
            end else begin
              for (int ch = 0; ch < 3; ch++) begin
                mix = int'(texel[8*ch +: 8]) * alpha +
                      int'(pixel_color[8*ch +: 8]) * (255 - alpha);
                predicted.color[8*ch +: 8] = mix[15:8];
              end
            end
          end
          expected_pixels.push_back(predicted);
        end
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (words_to_send.size() != 0 && gap_odds != 0 &&
                     $urandom_range(0, gap_odds - 1) == 0) begin
          gap_left = $urandom_range(0, 6);
          in_valid <= 1'b0;
        end else if (words_to_send.size() != 0) begin
          next_word = words_to_send.pop_front();
          in_valid    <= 1'b1;
          req_type    <= next_word.req;
          texel_index <= next_word.index;
          texel_value <= next_word.texel;
          pixel_x     <= next_word.x;
          pixel_y     <= next_word.y;
          pixel_color <= next_word.color;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result word in order and throttles out_ready.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: result with none pending, color %h covered %b",
                   $time, out_color, covered);
          mismatches++;
        end else begin
          seen = expected_pixels.pop_front();
          if (out_color !== seen.color) begin
            $display("%0t: out_color expected %h actual %h", $time, seen.color, out_color);
            mismatches++;
          end
          if (covered !== seen.covered) begin
            $display("%0t: covered expected %b actual %b", $time, seen.covered, covered);
            mismatches++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0) begin
        stall_left = $urandom_range(0, 6);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("rotated_sprite_alpha_overlay verification failed");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    gap_odds   = 3;
    stall_odds = 3;

    // Reset registers give a zero-sized texture: nothing is covered.
    push_load(16'h0000, 32'hFFFF_FFFF);
    push_load(16'hFFFF, 32'h0000_0000);
    push_load(16'hA5A5, 32'h5A5A_5A5A);
    push_pixel(12'd0, 12'd0, 32'h0000_0000);
    push_pixel(12'd4095, 12'd4095, 32'hFFFF_FFFF);
    push_pixel(12'hAAA, 12'h555, 32'h1234_5678);
    drain_pipe();

    // Unit scale, no rotation: screen pixel equals texel. Alpha extremes.
    set_geometry(4096, 0, 0, 0, 16, 16);
    push_load(16'd0, 32'hFF11_2233);
    push_pixel(12'd0, 12'd0, 32'hAABB_CCDD);
    push_load(16'd1, 32'h00AA_BBCC);
    push_pixel(12'd1, 12'd0, 32'hFFFF_FFFF);
    push_load(16'd2, 32'h80FF_00FF);
    push_pixel(12'd2, 12'd0, 32'h00FF_00FF);
    push_load(16'd3, 32'h01FF_FFFF);
    push_pixel(12'd3, 12'd0, 32'h0000_0000);
    push_load(16'd255, 32'hFE00_0000);
    push_pixel(12'd15, 12'd15, 32'hFFFF_FFFF);
    push_pixel(12'd16, 12'd0, $urandom);
    push_pixel(12'd0, 12'd16, $urandom);
    drain_pipe();

    // Width zero with a nonzero height still covers nothing.
    set_geometry(4096, 0, 0, 0, 0, 16);
    push_pixel(12'd0, 12'd0, 32'hDEAD_BEEF);
    drain_pipe();

    // Oversized texture: rows past the store read as clear. Offset of -1/256
    // checks the floor on the left edge.
    set_geometry(4096, 0, -1, 0, 511, 511);
    push_pixel(12'd0, 12'd5, 32'h1357_9BDF);
    push_pixel(12'd1, 12'd5, 32'h2468_ACE0);
    push_pixel(12'd3, 12'd200, 32'hFFFF_FFFF);
    push_pixel(12'd510, 12'd510, 32'h8040_2010);
    drain_pipe();

    for (int p = 0; p < PHASES; p++) begin
      // every third phase runs without idling; the final one too
      if (p % 3 == 0 || p == PHASES - 1) begin
        gap_odds   = 0;
        stall_odds = 0;
      end else begin
        gap_odds   = $urandom_range(2, 6);
        stall_odds = $urandom_range(2, 6);
      end
      plan_phase(p);
      run_random_phase(PHASE_WORDS);
      drain_pipe();
    end

    if (mismatches == 0) begin
      $display("rotated_sprite_alpha_overlay verification clean");
    end else begin
      $display("rotated_sprite_alpha_overlay verification failed");
    end
    $finish;
  end

endmodule
